FILE: rtl/console_io_port_controller_assert.svh
// assertion macros for the console i/o port controller
`ifndef CONSOLE_IO_PORT_CONTROLLER_ASSERT_SVH
`define CONSOLE_IO_PORT_CONTROLLER_ASSERT_SVH

// same-cycle implication, skipped during reset
`define CIOPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ciopc check failed");

// next-cycle implication, skipped during reset
`define CIOPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ciopc check failed");

// next-cycle implication, checked through reset as well
`define CIOPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ciopc check failed");

`endif

FILE: rtl/ciopc_pkg.sv
package ciopc_pkg;

   localparam int unsigned ADDR_W   = 24;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned NUM_PORT = 3;

   localparam logic [ADDR_W-1:0] WIN_BASE    = 24'hA10000;
   localparam logic [ADDR_W-1:0] BUSREQ_ADDR = 24'hA11100;
   localparam logic [ADDR_W-1:0] BUSREQ_LOW  = 24'hA11101;
   localparam logic [ADDR_W-1:0] RESET_ADDR  = 24'hA11200;
   localparam logic [ADDR_W-1:0] LOCK_BASE   = 24'hA14000;

   localparam logic [BYTE_W-1:0] VERSION_RESET = 8'hA0;
   localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] EXP_LINES     = 8'h7F;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      REG_VERSION = 4'd0,
      REG_DATA_A  = 4'd1,
      REG_DATA_B  = 4'd2,
      REG_DATA_C  = 4'd3,
      REG_DIR_A   = 4'd4,
      REG_DIR_B   = 4'd5,
      REG_DIR_C   = 4'd6,
      REG_TX_A    = 4'd7,
      REG_RX_A    = 4'd8,
      REG_CTRL_A  = 4'd9,
      REG_TX_B    = 4'd10,
      REG_RX_B    = 4'd11,
      REG_CTRL_B  = 4'd12,
      REG_TX_C    = 4'd13,
      REG_RX_C    = 4'd14,
      REG_CTRL_C  = 4'd15
   } reg_idx_type;

   typedef logic [1:0] port_idx_type;

   localparam port_idx_type PORT_A = 2'd0;
   localparam port_idx_type PORT_B = 2'd1;
   localparam port_idx_type PORT_C = 2'd2;

   // pin level seen on a pad port read
   function automatic logic [BYTE_W-1:0] pin_read(
      input logic              is_exp,
      input logic [BYTE_W-1:0] dat,
      input logic [BYTE_W-1:0] dir,
      input logic [BYTE_W-1:0] buttons
   );
      logic              sel;
      logic [BYTE_W-1:0] lines;
      sel = dir[6] ? dat[6] : 1'b1;
      if (is_exp) begin
         lines = EXP_LINES;
      end else if (sel) begin
         lines = {2'b00, ~buttons[6], ~buttons[5], ~buttons[3:0]};
      end else begin
         lines = {2'b00, ~buttons[7], ~buttons[4], 2'b00, ~buttons[1:0]};
      end
      return (dat & dir) | (lines & ~dir);
   endfunction

endpackage

FILE: rtl/console_io_port_controller.sv
// console i/o port controller
// req channel: one bus access per beat. req_tuser carries the access kind
// (0 read, 1 write); req_tdata carries the address, the write byte and the
// live button states of both pads.
// rsp channel: one beat per request, carrying the read byte (0 on writes),
// the coprocessor bus-request flag after the access and the reset release
// pulse (set on the write that takes the coprocessor out of reset).
// csr port: csr_wr_en writes csr_wr_data into the version register; the user
// must only do this while no access is in flight; not enforced by the block.
// latency: the response is valid the cycle after the request beat.
// throughput: one access per cycle; register decode and update sit between
// the request port and a single response register, and a new request is
// taken whenever that register is empty or being drained.
// reset: port, direction and serial registers clear to 0, the bus-request
// and reset flags set to 1, the version register loads 0xA0 and no response
// is pending.
// stall: while rsp_tready is low a pending response holds and req_tready
// stays low, so no access is lost or updates state early.
module console_io_port_controller
   import ciopc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] command
   input  logic [0:0]  req_tuser,
   // [23:0] address, [31:24] write_data, [39:32] pad_one_buttons,
   // [47:40] pad_two_buttons
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] bus_granted, [9] reset_release_pulse, [15:10] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [BYTE_W-1:0] version_ff;
   logic [BYTE_W-1:0] data_ff [NUM_PORT];
   logic [BYTE_W-1:0] dir_ff  [NUM_PORT];
   logic [BYTE_W-1:0] tx_ff   [NUM_PORT];
   logic [BYTE_W-1:0] ctrl_ff [NUM_PORT];
   logic [BYTE_W-1:0] data_in [NUM_PORT];
   logic [BYTE_W-1:0] dir_in  [NUM_PORT];
   logic [BYTE_W-1:0] tx_in   [NUM_PORT];
   logic [BYTE_W-1:0] ctrl_in [NUM_PORT];
   logic              bus_ff, bus_in;
   logic              crst_ff, crst_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic              req_accept;
   cmd_type           cmd;
   logic              wr;
   logic [ADDR_W-1:0] addr;
   logic [BYTE_W-1:0] wdata;
   logic [BYTE_W-1:0] pad_one;
   logic [BYTE_W-1:0] pad_two;
   reg_idx_type       reg_idx;
   logic [BYTE_W-1:0] rd;
   logic              pulse;
   port_idx_type      pidx;
   logic [BYTE_W-1:0] pbuttons;

   assign cmd     = cmd_type'(req_tuser[0]);
   assign wr      = (cmd == CMD_WRITE);
   assign addr    = req_tdata[23:0];
   assign wdata   = req_tdata[31:24];
   assign pad_one = req_tdata[39:32];
   assign pad_two = req_tdata[47:40];
   assign reg_idx = reg_idx_type'(addr[4:1]);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      rd       = UNMAPPED_BYTE;
      pulse    = 1'b0;
      bus_in   = bus_ff;
      crst_in  = crst_ff;
      data_in  = data_ff;
      dir_in   = dir_ff;
      tx_in    = tx_ff;
      ctrl_in  = ctrl_ff;
      pidx     = PORT_A;
      pbuttons = '0;
      if (addr[23:5] == WIN_BASE[23:5]) begin
         rd = '0;
         if (addr[0]) begin
            unique case (reg_idx)
               REG_VERSION: begin
                  rd = version_ff;
               end
               REG_DATA_A, REG_DATA_B, REG_DATA_C: begin
                  pidx = port_idx_type'(reg_idx - REG_DATA_A);
                  pbuttons = (pidx == PORT_A) ? pad_one :
                             (pidx == PORT_B) ? pad_two : '0;
                  if (wr) begin
                     data_in[pidx] = wdata;
                  end else begin
                     rd = pin_read(pidx == PORT_C, data_ff[pidx], dir_ff[pidx],
                                   pbuttons);
                  end
               end
               REG_DIR_A, REG_DIR_B, REG_DIR_C: begin
                  pidx = port_idx_type'(reg_idx - REG_DIR_A);
                  if (wr) dir_in[pidx] = wdata;
                  else rd = dir_ff[pidx];
               end
               REG_TX_A, REG_TX_B, REG_TX_C: begin
                  pidx = (reg_idx == REG_TX_A) ? PORT_A :
                         (reg_idx == REG_TX_B) ? PORT_B : PORT_C;
                  if (wr) tx_in[pidx] = wdata;
                  else rd = tx_ff[pidx];
               end
               REG_CTRL_A, REG_CTRL_B, REG_CTRL_C: begin
                  pidx = (reg_idx == REG_CTRL_A) ? PORT_A :
                         (reg_idx == REG_CTRL_B) ? PORT_B : PORT_C;
                  if (wr) ctrl_in[pidx] = wdata;
                  else rd = ctrl_ff[pidx];
               end
               REG_RX_A, REG_RX_B, REG_RX_C: begin
                  rd = '0;
               end
            endcase
         end
      end else if (addr == BUSREQ_ADDR) begin
         if (wr) bus_in = wdata[0];
         rd = {7'd0, !bus_in};
      end else if (addr == BUSREQ_LOW) begin
         rd = '0;
      end else if (addr[23:1] == RESET_ADDR[23:1]) begin
         rd = '0;
         if (wr) begin
            crst_in = !wdata[0];
            pulse   = crst_ff && wdata[0];
         end
      end else if (addr[23:2] == LOCK_BASE[23:2]) begin
         rd = '0;
      end
      if (wr) rd = '0;
      rsp_data_in  = {6'd0, pulse, bus_in, rd};
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= VERSION_RESET;
         bus_ff       <= 1'b1;
         crst_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PORT; i++) begin
            data_ff[i] <= '0;
            dir_ff[i]  <= '0;
            tx_ff[i]   <= '0;
            ctrl_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) version_ff <= csr_wr_data;
         if (req_accept) begin
            bus_ff  <= bus_in;
            crst_ff <= crst_in;
            data_ff <= data_in;
            dir_ff  <= dir_in;
            tx_ff   <= tx_in;
            ctrl_ff <= ctrl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_data_ff <= rsp_data_in;
   end

`include "console_io_port_controller_assert.svh"

   `CIOPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid_ff)
   `CIOPC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff)
   `CIOPC_ASSERT_SAME(a_granted_tracks_flag, clock, reset, rsp_valid_ff, rsp_data_ff[8] == bus_ff)
   `CIOPC_ASSERT_SAME(a_pulse_flag_clear, clock, reset, rsp_valid_ff && rsp_data_ff[9], !crst_ff)

endmodule
